### sv/bst_pkg.sv
`timescale 1ns / 1ps
package bst_pkg;

    // coordinate and accumulator widths
    localparam int COORD_W = 32;
    localparam int ACC_W   = 48;
    localparam int NUM_W   = 52;
    localparam int RVAL_W  = 53;
    localparam int WIDE_W  = 58;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [RVAL_W-1:0]  t_rval;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    localparam t_wide ACC_MAX = t_wide'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
    localparam t_wide ACC_MIN = t_wide'(-(64'sd1 <<< (ACC_W - 1)));

    // clamp a wide sum to the signed accumulator range
    function automatic t_acc sat_acc(input t_wide v);
        t_acc r;
        if (v > ACC_MAX) begin
            r = ACC_MAX[ACC_W-1:0];
        end else if (v < ACC_MIN) begin
            r = ACC_MIN[ACC_W-1:0];
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

### sv/bst_req_if.sv
`timescale 1ns / 1ps
interface bst_req_if;
    import bst_pkg::*;
    logic   valid;
    logic   ready;
    t_coord pos_x;
    t_coord pos_y;
    t_coord pos_z;
    t_coord left_x;
    t_coord left_y;
    t_coord left_z;
    t_coord right_x;
    t_coord right_y;
    t_coord right_z;
    logic   left_is_vector;
    logic   right_is_vector;
    logic   last_point;

    modport source (output valid, pos_x, pos_y, pos_z, left_x, left_y, left_z,
                    right_x, right_y, right_z, left_is_vector, right_is_vector,
                    last_point, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, left_x, left_y, left_z,
                  right_x, right_y, right_z, left_is_vector, right_is_vector,
                  last_point, output ready);
endinterface

### sv/bst_res_if.sv
`timescale 1ns / 1ps
interface bst_res_if;
    import bst_pkg::*;
    logic   valid;
    logic   ready;
    t_coord out_x;
    t_coord out_y;
    t_coord out_z;
    logic   run_end;

    modport source (output valid, out_x, out_y, out_z, run_end, input ready);
    modport sink (input valid, out_x, out_y, out_z, run_end, output ready);
endinterface

### sv/bezier_spline_tessellator_core.sv
// Sequence: a vector segment or single point goes from START to POS; a curved segment
// runs SET1, SET2, 9 divisions (DLD then DIV each), INIT, then resolution EMIT steps.
// Throughput: one request at a time; the shared restoring divider (one quotient bit
// per cycle) sets the rate; results leave one per cycle once set up, unless output stalls.
// Reset (synchronous, active low) clears control state and spline history,
// sets resolution to 12 and cyclic to 0.
`timescale 1ns / 1ps
module bezier_spline_tessellator_core #(
    parameter int MAX_RESOLUTION = 32,
    parameter int COORD_BITS     = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bst_req_if.sink            i_req,
    bst_res_if.source          o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bst_pkg::*;

    localparam int NW    = $clog2(MAX_RESOLUTION + 1);
    localparam int DEN_W = 3 * NW;
    localparam int OW    = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam logic signed [63:0] OMAX = (64'sd1 <<< (OW - 1)) - 64'sd1;
    localparam logic signed [63:0] OMIN = -(64'sd1 <<< (OW - 1));
    localparam logic [5:0] DIV_LAST = 6'(NUM_W - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_SET1  = 4'd2;
    localparam logic [3:0] S_SET2  = 4'd3;
    localparam logic [3:0] S_DLD   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_INIT  = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_POS   = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd9;

    localparam logic REG_RES = 1'b0;
    localparam logic REG_CYC = 1'b1;

    // saturate to the output coordinate width
    function automatic t_coord sat_out(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (c > OMAX) c = OMAX;
        if (c < OMIN) c = OMIN;
        return c[COORD_W-1:0];
    endfunction

    // configuration
    logic [5:0] r_res;
    logic       r_cyc;
    logic       w_wr;
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= 6'd12;
            r_cyc <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_RES: r_res <= pwdata[5:0];
                REG_CYC: r_cyc <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RES: prdata = {26'd0, r_res};
            REG_CYC: prdata = {31'd0, r_cyc};
            default: prdata = '0;
        endcase
    end

    // control and history
    logic [3:0]      r_state;
    logic            r_hv;
    logic            r_seg;
    logic            r_final;
    logic            r_last, r_lvec, r_rvec, r_prvec, r_flvec;
    t_coord          r_in_pos [3];
    t_coord          r_in_left [3];
    t_coord          r_in_right [3];
    t_coord          r_prev_pos [3];
    t_coord          r_prev_right [3];
    t_coord          r_first_pos [3];
    t_coord          r_first_left [3];

    logic [NW-1:0]   r_n;
    logic [2*NW-1:0] r_n2;
    logic [DEN_W-1:0] r_n3;
    logic [NW-1:0]   r_cnt;

    logic [1:0]      r_da, r_dt;
    logic [5:0]      r_dcnt;
    logic [NUM_W-1:0] r_dvd;
    logic [DEN_W-1:0] r_rem;
    logic            r_neg;
    t_rval           r_r [3][3];

    t_acc            r_q0 [3];
    t_acc            r_q1 [3];
    t_acc            r_q2 [3];
    t_acc            r_q3 [3];

    logic            r_ov;
    t_coord          r_ox, r_oy, r_oz;
    logic            r_oend;

    logic            w_acc, w_slot, w_vec0, w_vec1, w_emit;
    logic [NW-1:0]   w_nclamp;
    t_coord          w_p0 [3];
    t_coord          w_sp0, w_sp1, w_sp2, w_sp3;
    logic signed [37:0] w_d1, w_d2, w_d3, w_num;
    logic [36:0]     w_mag;
    logic [DEN_W-1:0] w_den;
    logic [DEN_W:0]  w_rsh;
    logic            w_ge;
    logic [53:0]     w_mround;

    assign w_acc      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_slot     = !r_ov || o_res.ready;
    assign w_vec0     = r_prvec && r_lvec;
    assign w_vec1     = r_rvec && r_flvec;
    assign w_emit     = w_slot && (r_state == S_EMIT || r_state == S_POS);

    // clamp resolution into 1..MAX_RESOLUTION
    always_comb begin
        if (r_res == 6'd0) begin
            w_nclamp = NW'(1);
        end else if (32'(r_res) > 32'(MAX_RESOLUTION)) begin
            w_nclamp = NW'(MAX_RESOLUTION);
        end else begin
            w_nclamp = NW'(r_res);
        end
    end

    // segment control points: start, handle, handle, end
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_p0[a] = r_seg ? r_in_pos[a] : r_prev_pos[a];
        end
        w_sp0 = r_seg ? r_in_pos[r_da]     : r_prev_pos[r_da];
        w_sp1 = r_seg ? r_in_right[r_da]   : r_prev_right[r_da];
        w_sp2 = r_seg ? r_first_left[r_da] : r_in_left[r_da];
        w_sp3 = r_seg ? r_first_pos[r_da]  : r_in_pos[r_da];
    end

    // difference terms and rounded numerator for the current division
    always_comb begin
        w_d1 = 38'(w_sp1) - 38'(w_sp0);
        w_d2 = 38'(w_sp0) - (38'(w_sp1) <<< 1) + 38'(w_sp2);
        w_d3 = 38'(w_sp3) - 38'(w_sp0) + 38'sd3 * (38'(w_sp1) - 38'(w_sp2));
        case (r_dt)
            2'd0:    w_num = 38'sd3 * w_d1;
            2'd1:    w_num = 38'sd3 * w_d2;
            default: w_num = w_d3;
        endcase
        w_mag = w_num[37] ? 37'(-w_num) : w_num[36:0];
        case (r_dt)
            2'd0:    w_den = DEN_W'(r_n);
            2'd1:    w_den = DEN_W'(r_n2);
            default: w_den = r_n3;
        endcase
        w_mround = {1'b0, w_mag, 16'd0} + 54'(w_den >> 1);
        w_rsh    = {r_rem, r_dvd[NUM_W-1]};
        w_ge     = (w_rsh >= {1'b0, w_den});
    end

    // result valid: set on a new result, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hv    <= 1'b0;
            r_prvec <= 1'b0;
            r_flvec <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_prev_pos[a]   <= '0;
                r_prev_right[a] <= '0;
                r_first_pos[a]  <= '0;
                r_first_left[a] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_in_pos[0]   <= i_req.pos_x;
                        r_in_pos[1]   <= i_req.pos_y;
                        r_in_pos[2]   <= i_req.pos_z;
                        r_in_left[0]  <= i_req.left_x;
                        r_in_left[1]  <= i_req.left_y;
                        r_in_left[2]  <= i_req.left_z;
                        r_in_right[0] <= i_req.right_x;
                        r_in_right[1] <= i_req.right_y;
                        r_in_right[2] <= i_req.right_z;
                        r_lvec <= i_req.left_is_vector;
                        r_rvec <= i_req.right_is_vector;
                        r_last <= i_req.last_point;
                        r_seg  <= 1'b0;
                        if (!r_hv) begin
                            r_first_pos[0]  <= i_req.pos_x;
                            r_first_pos[1]  <= i_req.pos_y;
                            r_first_pos[2]  <= i_req.pos_z;
                            r_first_left[0] <= i_req.left_x;
                            r_first_left[1] <= i_req.left_y;
                            r_first_left[2] <= i_req.left_z;
                            r_flvec <= i_req.left_is_vector;
                        end
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (!r_hv) begin
                        if (r_last) begin
                            r_seg   <= 1'b1;
                            r_final <= 1'b1;
                            r_state <= S_POS;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end else begin
                        r_final <= !r_last;
                        r_state <= w_vec0 ? S_POS : S_SET1;
                    end
                end
                S_SET1: begin
                    r_n     <= w_nclamp;
                    r_n2    <= (2*NW)'(w_nclamp) * (2*NW)'(w_nclamp);
                    r_da    <= 2'd0;
                    r_dt    <= 2'd0;
                    r_state <= S_SET2;
                end
                S_SET2: begin
                    r_n3    <= DEN_W'(r_n2) * DEN_W'(r_n);
                    r_state <= S_DLD;
                end
                S_DLD: begin
                    r_dvd   <= w_mround[NUM_W-1:0];
                    r_neg   <= w_num[37];
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= w_ge ? DEN_W'(w_rsh - {1'b0, w_den}) : w_rsh[DEN_W-1:0];
                    r_dvd  <= {r_dvd[NUM_W-2:0], w_ge};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == DIV_LAST) begin
                        r_r[r_da][r_dt] <= r_neg ? -t_rval'({r_dvd[NUM_W-2:0], w_ge})
                                                 : t_rval'({r_dvd[NUM_W-2:0], w_ge});
                        if (r_dt == 2'd2) begin
                            r_dt <= 2'd0;
                            if (r_da == 2'd2) begin
                                r_state <= S_INIT;
                            end else begin
                                r_da    <= r_da + 2'd1;
                                r_state <= S_DLD;
                            end
                        end else begin
                            r_dt    <= r_dt + 2'd1;
                            r_state <= S_DLD;
                        end
                    end
                end
                S_INIT: begin
                    for (int a = 0; a < 3; a++) begin
                        r_q0[a] <= {w_p0[a], 16'd0};
                        r_q1[a] <= sat_acc(t_wide'(r_r[a][0]) + t_wide'(r_r[a][1])
                                           + t_wide'(r_r[a][2]));
                        r_q2[a] <= sat_acc((t_wide'(r_r[a][1]) <<< 1)
                                           + t_wide'(r_r[a][2]) * 58'sd6);
                        r_q3[a] <= sat_acc(t_wide'(r_r[a][2]) * 58'sd6);
                    end
                    r_cnt   <= r_n;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_slot) begin
                        r_ox   <= sat_out(64'((49'(r_q0[0]) + 49'sd32768) >>> 16));
                        r_oy   <= sat_out(64'((49'(r_q0[1]) + 49'sd32768) >>> 16));
                        r_oz   <= sat_out(64'((49'(r_q0[2]) + 49'sd32768) >>> 16));
                        r_oend <= r_final && (r_cnt == NW'(1));
                        for (int a = 0; a < 3; a++) begin
                            r_q0[a] <= sat_acc(t_wide'(r_q0[a]) + t_wide'(r_q1[a]));
                            r_q1[a] <= sat_acc(t_wide'(r_q1[a]) + t_wide'(r_q2[a]));
                            r_q2[a] <= sat_acc(t_wide'(r_q2[a]) + t_wide'(r_q3[a]));
                        end
                        r_cnt <= r_cnt - NW'(1);
                        if (r_cnt == NW'(1)) r_state <= S_NEXT;
                    end
                end
                S_POS: begin
                    if (w_slot) begin
                        r_ox    <= sat_out(64'(w_p0[0]));
                        r_oy    <= sat_out(64'(w_p0[1]));
                        r_oz    <= sat_out(64'(w_p0[2]));
                        r_oend  <= r_final;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (!r_seg && r_last && r_hv) begin
                        // closing segment or final position
                        r_seg   <= 1'b1;
                        r_final <= 1'b1;
                        if (r_cyc) begin
                            r_state <= w_vec1 ? S_POS : S_SET1;
                        end else begin
                            r_state <= S_POS;
                        end
                    end else begin
                        for (int a = 0; a < 3; a++) begin
                            r_prev_pos[a]   <= r_in_pos[a];
                            r_prev_right[a] <= r_in_right[a];
                        end
                        r_prvec <= r_rvec;
                        r_hv    <= !r_last;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid   = r_ov;
    assign o_res.out_x   = r_ox;
    assign o_res.out_y   = r_oy;
    assign o_res.out_z   = r_oz;
    assign o_res.run_end = r_oend;

`ifndef NO_ASSERTIONS
    // emission never runs with an exhausted count
    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_cnt != '0)
        else $error("emit with zero count");

    // a request always starts the sequencer
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_state == S_START)
        else $error("request did not start sequencer");

    // division indexes stay within the three axes and three terms
    a_div_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_DLD) |-> (r_da != 2'd3 && r_dt != 2'd3))
        else $error("division index out of range");

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_res.ready) |=> $stable(r_ox) && $stable(r_oend))
        else $error("pending result overwritten");
`endif

endmodule
